// ===== rtl/alist_pkg.sv =====
package alist_pkg;

  // request kinds carried in tuser on the input side
  typedef enum logic [2:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_BACK  = 3'd1,
    REQ_INS_AT    = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_DEL_BACK  = 3'd4,
    REQ_DEL_AT    = 3'd5,
    REQ_SEARCH    = 3'd6,
    REQ_ROTATE    = 3'd7
  } req_e;

  // result status carried in tuser on the output side
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_BADAMT   = 3'd5
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_EXEC = 3'd1,
    S_SCAN = 3'd2,
    S_MOD  = 3'd3,
    S_ROT  = 3'd4,
    S_DONE = 3'd5
  } state_e;

  // what every cell of the row does this cycle
  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_INSERT = 3'd1,
    CELL_REMOVE = 3'd2,
    CELL_ROTATE = 3'd3
  } cell_op_e;

  localparam int unsigned WordW = 32;
  localparam int unsigned PosW  = 8;

  typedef logic [WordW-1:0] word_t;
  typedef logic [PosW-1:0]  pos_t;

  // broadcast control for the row of cells
  typedef struct packed {
    cell_op_e op;
    pos_t     pos;   // insert or remove position
    pos_t     last;  // index of the last held entry, for rotate
  } cell_ctrl_t;

endpackage

// ===== rtl/alist_cell.sv =====
module alist_cell (
  input  logic                clk_i,
  input  alist_pkg::pos_t     idx_i,    // fixed place of this cell in the row
  input  alist_pkg::cell_ctrl_t ctrl_i,
  input  alist_pkg::word_t    data_i,   // new word, rotate head or search key
  input  alist_pkg::word_t    left_i,   // neighbor at idx - 1
  input  alist_pkg::word_t    right_i,  // neighbor at idx + 1
  output alist_pkg::word_t    data_o,
  output logic                match_o
);
  import alist_pkg::*;

  word_t data_q, data_d;

  // per-cell move decision
  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (idx_i == ctrl_i.pos) begin
          data_d = data_i;
        end else if (idx_i > ctrl_i.pos) begin
          data_d = left_i;
        end
      end
      CELL_REMOVE: begin
        if (idx_i >= ctrl_i.pos) begin
          data_d = right_i;
        end
      end
      CELL_ROTATE: begin
        if (idx_i == ctrl_i.last) begin
          data_d = data_i;
        end else if (idx_i < ctrl_i.last) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = (data_q == data_i);

endmodule

// ===== rtl/alist_mod.sv =====
module alist_mod #(
  parameter int unsigned CW = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [30:0]   dividend_i,
  input  logic [CW-1:0] divisor_i,
  output logic          done_o,
  output logic [CW-1:0] rem_o
);
  localparam int unsigned NB = 31;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [4:0]    cnt_q, cnt_d;
  logic [NB-1:0] shift_q, shift_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [CW:0]   trial;
  logic [CW-1:0] rem_next;

  // one restoring step per cycle, most significant bit first
  always_comb begin
    trial    = {rem_q, shift_q[NB-1]};
    rem_next = trial[CW-1:0];
    if (trial >= {1'b0, divisor_i}) begin
      rem_next = CW'(trial - {1'b0, divisor_i});
    end
  end

  // step control
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    rem_d   = rem_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = 5'(NB - 1);
      shift_d = dividend_i;
      rem_d   = '0;
    end else if (busy_q) begin
      shift_d = {shift_q[NB-2:0], 1'b0};
      rem_d   = rem_next;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/array_list_engine.sv =====
// bounded ordered list of signed 32-bit words, up to CAPACITY entries
// input channel s_axis: tuser carries the request kind, tdata the value
// and the position; one request is taken at a time, tready is high only
// while the engine is idle
// output channel m_axis: one result per request, tuser carries the status,
// tdata the removed word, the match index and the count after the request
// the result sits in an output register, so the engine goes back to idle
// and takes the next request while that result waits for tready
// from accept to result valid: inserts, deletes and rejected requests
// pass the execute and done states, then the output register; search
// walks the match flags one entry at a time up to the first match and
// stops at once on a miss; rotate waits for the bit-serial modulo unit,
// then shifts the cell row one place left per step (count - amount mod
// count steps, none when that remainder is zero, at most CAPACITY - 1)
// in every shift, insert and delete all cells of the row update together,
// each taking a neighbor's word, the broadcast word or its own
// reset empties the list and drops any pending result; entry words are
// not cleared, only entries below the count are ever read
module array_list_engine #(
  parameter int unsigned CAPACITY = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // value[31:0], position[39:32]
  input  logic [2:0]  s_axis_tuser,  // req_type[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // data_out[31:0], found_index[34:32],
                                     // count_after[38:35], zero[39]
  output logic [2:0]  m_axis_tuser   // status[2:0]
);
  import alist_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  state_e        state_q, state_d;
  req_e          req_q;
  word_t         val_q;
  pos_t          pos_q;
  logic [CW-1:0] count_q, count_d;
  logic [CAPACITY-1:0] match_q, match_d;
  logic [IW-1:0] scan_q, scan_d;
  logic [CW-1:0] steps_q, steps_d;
  status_e       res_status_q, res_status_d;
  word_t         res_data_q, res_data_d;
  logic [2:0]    res_idx_q, res_idx_d;

  logic          out_valid_q;
  status_e       out_status_q;
  word_t         out_data_q;
  logic [2:0]    out_idx_q;
  logic [3:0]    out_count_q;
  logic          out_free;
  logic          in_take;

  status_e       ex_status;
  pos_t          ex_pos;
  logic          ex_ins, ex_del;
  logic [CW-1:0] count_dec;

  cell_ctrl_t    ctrl;
  word_t         bcast;
  word_t         cell_q [CAPACITY];
  logic [CAPACITY-1:0] cell_match;
  logic [CAPACITY-1:0] match_vec;

  logic          mod_start;
  logic          mod_done;
  logic [CW-1:0] mod_rem;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign count_dec     = count_q - CW'(1);

  // row of cells, each neighbor wired to the next
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    word_t left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_q[i+1];
    end
    alist_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (PosW'(i)),
      .ctrl_i (ctrl),
      .data_i (bcast),
      .left_i (left_w),
      .right_i(right_w),
      .data_o (cell_q[i]),
      .match_o(cell_match[i])
    );
  end

  // rotate feeds the head into the tail, everything else uses the value
  assign bcast = (ctrl.op == CELL_ROTATE) ? cell_q[0] : val_q;

  // matches only count among held entries
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_vec[i] = cell_match[i] && (PosW'(i) < PosW'(count_q));
    end
  end

  alist_mod #(.CW(CW)) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .dividend_i(val_q[30:0]),
    .divisor_i (count_q),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  // request decode and rejection checks
  always_comb begin
    ex_status = ST_OK;
    ex_pos    = pos_q;
    ex_ins    = 1'b0;
    ex_del    = 1'b0;
    unique case (req_q) inside
      REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_AT: begin
        ex_ins = 1'b1;
        if (req_q == REQ_INS_FRONT) begin
          ex_pos = '0;
        end else if (req_q == REQ_INS_BACK) begin
          ex_pos = PosW'(count_q);
        end
        if (count_q == CW'(CAPACITY)) begin
          ex_status = ST_FULL;
        end else if (req_q == REQ_INS_AT && pos_q > PosW'(count_q)) begin
          ex_status = ST_BADPOS;
        end
      end
      REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_AT: begin
        ex_del = 1'b1;
        if (req_q == REQ_DEL_FRONT) begin
          ex_pos = '0;
        end else if (req_q == REQ_DEL_BACK) begin
          ex_pos = PosW'(count_dec);
        end
        if (count_q == '0) begin
          ex_status = ST_EMPTY;
        end else if (req_q == REQ_DEL_AT && pos_q >= PosW'(count_q)) begin
          ex_status = ST_BADPOS;
        end
      end
      REQ_SEARCH: begin
        if (count_q == '0) begin
          ex_status = ST_EMPTY;
        end
      end
      REQ_ROTATE: begin
        if (count_q == '0) begin
          ex_status = ST_EMPTY;
        end else if (val_q[31]) begin
          ex_status = ST_BADAMT;
        end
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_take) state_d = S_EXEC;
      S_EXEC: begin
        if (ex_status != ST_OK) begin
          state_d = S_DONE;
        end else if (req_q == REQ_SEARCH) begin
          state_d = S_SCAN;
        end else if (req_q == REQ_ROTATE) begin
          state_d = S_MOD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SCAN: if (match_q[0] || match_q == '0) state_d = S_DONE;
      S_MOD:  if (mod_done) state_d = S_ROT;
      S_ROT:  if (steps_q == '0) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath control per state
  always_comb begin
    count_d      = count_q;
    match_d      = match_q;
    scan_d       = scan_q;
    steps_d      = steps_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    res_idx_d    = res_idx_q;
    mod_start    = 1'b0;
    ctrl.op      = CELL_HOLD;
    ctrl.pos     = ex_pos;
    ctrl.last    = PosW'(count_dec);
    unique case (state_q)
      S_EXEC: begin
        res_status_d = ex_status;
        res_data_d   = '0;
        res_idx_d    = '0;
        if (ex_status == ST_OK) begin
          if (ex_ins) begin
            ctrl.op = CELL_INSERT;
            count_d = count_q + CW'(1);
          end else if (ex_del) begin
            ctrl.op    = CELL_REMOVE;
            res_data_d = cell_q[ex_pos[IW-1:0]];
            count_d    = count_dec;
          end else if (req_q == REQ_SEARCH) begin
            match_d = match_vec;
            scan_d  = '0;
          end else begin
            mod_start = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (match_q[0]) begin
          res_idx_d = 3'(scan_q);
        end else if (match_q == '0) begin
          res_status_d = ST_NOTFOUND;
        end else begin
          match_d = match_q >> 1;
          scan_d  = scan_q + IW'(1);
        end
      end
      S_MOD: begin
        // right by k is left by count - k
        if (mod_done) begin
          steps_d = (mod_rem == '0) ? '0 : count_q - mod_rem;
        end
      end
      S_ROT: begin
        if (steps_q != '0) begin
          ctrl.op = CELL_ROTATE;
          steps_d = steps_q - CW'(1);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request, work and result registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q <= req_e'(s_axis_tuser[2:0]);
      val_q <= s_axis_tdata[31:0];
      pos_q <= s_axis_tdata[39:32];
    end
    match_q      <= match_d;
    scan_q       <= scan_d;
    steps_q      <= steps_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    res_idx_q    <= res_idx_d;
    if (state_q == S_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_data_q   <= res_data_q;
      out_idx_q    <= res_idx_q;
      out_count_q  <= 4'(count_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {1'b0, out_count_q, out_idx_q, out_data_q};

`ifndef SYNTH
  // count stays within capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("list count above capacity");

  // the count moves only when a request is carried out
  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_EXEC |=> count_q == $past(count_q))
    else $error("count changed outside request execution");

  // rotate never shifts a full turn or more
  a_rot_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROT |-> steps_q < count_q)
    else $error("rotate step count out of range");
`endif

endmodule

// ===== tb/sv/array_list_engine_test.sv =====
`timescale 1ns / 1ps

module array_list_engine_test;
  import alist_pkg::*;

  localparam int unsigned CAPACITY  = 8;
  localparam int unsigned CalmTail  = 150;  // last requests get no random gaps or stalls
  localparam int unsigned HoldAt    = 300;  // result count that starts the long hold-off
  localparam int unsigned HoldLen   = 100;
  localparam int unsigned DrainLen  = 60;

  // one list request as offered on the input stream
  typedef struct {
    req_e  kind;
    word_t value;
    pos_t  position;
    bit    drain_first;  // hold back until all results are in
  } list_req_t;

  // one result as seen on the output stream
  typedef struct {
    status_e    status;
    word_t      data_out;
    logic [2:0] found_index;
    logic [3:0] count_after;
  } list_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;  // value[31:0], position[39:32]
  logic [2:0]  s_axis_tuser  = '0;  // req_type[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // data_out[31:0], found_index[34:32],
                                    // count_after[38:35], zero[39]
  logic [2:0]  m_axis_tuser;        // status[2:0]

  list_req_t    req_q[$];
  list_result_t want_q[$];
  list_req_t    cur_req;

  // shadow of the list contents
  word_t       list_store [CAPACITY];
  int unsigned list_held = 0;

  int unsigned total_reqs = 0;
  int unsigned sent_cnt   = 0;
  int unsigned got_cnt    = 0;
  int unsigned fail_cnt   = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;

  word_t word_pool [8];

  array_list_engine #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // applies one request to the shadow list and returns its result
  function automatic list_result_t apply_list_req(list_req_t r);
    list_result_t res;
    word_t        rotated [CAPACITY];
    int unsigned  at, k, i, d;
    res.status      = ST_OK;
    res.data_out    = '0;
    res.found_index = '0;
    case (r.kind)
      REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_AT: begin
        if (list_held >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (r.kind == REQ_INS_AT && r.position > list_held) begin
          res.status = ST_BADPOS;
        end else begin
          if (r.kind == REQ_INS_FRONT) at = 0;
          else if (r.kind == REQ_INS_BACK) at = list_held;
          else at = r.position;
          for (i = list_held; i > at; i--) list_store[i] = list_store[i-1];
          list_store[at] = r.value;
          list_held++;
        end
      end
      REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_AT: begin
        if (list_held == 0) begin
          res.status = ST_EMPTY;
        end else if (r.kind == REQ_DEL_AT && r.position >= list_held) begin
          res.status = ST_BADPOS;
        end else begin
          if (r.kind == REQ_DEL_FRONT) at = 0;
          else if (r.kind == REQ_DEL_BACK) at = list_held - 1;
          else at = r.position;
          res.data_out = list_store[at];
          for (i = at; i + 1 < list_held; i++) list_store[i] = list_store[i+1];
          list_held--;
        end
      end
      REQ_SEARCH: begin
        if (list_held == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.status = ST_NOTFOUND;
          for (i = list_held; i > 0; i--) begin
            // walk down so the lowest match wins
            if (list_store[i-1] == r.value) begin
              res.status      = ST_OK;
              res.found_index = 3'(i - 1);
            end
          end
        end
      end
      default: begin
        if (list_held == 0) begin
          res.status = ST_EMPTY;
        end else if (r.value[31]) begin
          res.status = ST_BADAMT;
        end else begin
          k = r.value % list_held;
          for (i = 0; i < list_held; i++) begin
            d = i + k;
            if (d >= list_held) d -= list_held;
            rotated[d] = list_store[i];
          end
          for (i = 0; i < list_held; i++) list_store[i] = rotated[i];
        end
      end
    endcase
    res.count_after = 4'(list_held);
    return res;
  endfunction

  task automatic add_req(req_e kind, word_t value, pos_t position);
    list_req_t r;
    r.kind        = kind;
    r.value       = value;
    r.position    = position;
    r.drain_first = 1'b0;
    req_q.push_back(r);
  endtask

  // mostly words from a small pool so searches hit and duplicates occur
  function automatic word_t pick_word();
    if ($urandom_range(0, 9) < 7) return word_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // request driver
  always @(posedge clk_i) begin
    bit offer;
    offer = s_axis_tvalid;
    if (!rst_ni) begin
      offer = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        want_q.push_back(apply_list_req(cur_req));
        sent_cnt++;
        offer = 1'b0;
        if (sent_cnt + CalmTail < total_reqs && $urandom_range(0, 7) == 0)
          gap_left = $urandom_range(1, 15);
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_q.size() > 0 &&
                     (!req_q[0].drain_first || want_q.size() == 0)) begin
          cur_req = req_q.pop_front();
          s_axis_tuser <= cur_req.kind;
          s_axis_tdata <= {cur_req.position, cur_req.value};
          offer = 1'b1;
        end
      end
    end
    s_axis_tvalid <= offer;
  end

  // result monitor and back-pressure
  always @(posedge clk_i) begin
    list_result_t want;
    bit           rdy;
    rdy = 1'b0;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_cnt++;
        if (want_q.size() == 0) begin
          $error("result with no request pending: tuser %0d tdata %h",
                 m_axis_tuser, m_axis_tdata);
          fail_cnt++;
        end else begin
          want = want_q.pop_front();
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
            fail_cnt++;
          end
          if (m_axis_tdata[31:0] !== want.data_out) begin
            $error("data_out: expected %h, got %h", want.data_out, m_axis_tdata[31:0]);
            fail_cnt++;
          end
          if (m_axis_tdata[34:32] !== want.found_index) begin
            $error("found_index: expected %0d, got %0d",
                   want.found_index, m_axis_tdata[34:32]);
            fail_cnt++;
          end
          if (m_axis_tdata[38:35] !== want.count_after) begin
            $error("count_after: expected %0d, got %0d",
                   want.count_after, m_axis_tdata[38:35]);
            fail_cnt++;
          end
        end
      end
      // one long hold-off so the engine backs up into its input
      if (!hold_done && got_cnt >= HoldAt) begin
        hold_done = 1'b1;
        hold_left = HoldLen;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (got_cnt + CalmTail < total_reqs && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
      end else begin
        rdy = 1'b1;
      end
    end
    m_axis_tready <= rdy;
  end

  initial begin
    list_req_t r;
    req_e      ins_kinds [3];
    req_e      del_kinds [3];
    int        mode, roll, ins_pct, del_pct, srch_pct;
    ins_kinds = '{REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_AT};
    del_kinds = '{REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_AT};
    mode = 0;
    ins_pct = 0;
    del_pct = 0;
    srch_pct = 0;

    // directed: rejects on empty, fill to capacity, rejects on full, then searches, rotates and deletes
    add_req(REQ_DEL_FRONT, 32'd0, 8'd0);
    add_req(REQ_DEL_AT, 32'd0, 8'd0);
    add_req(REQ_SEARCH, 32'd0, 8'd0);
    add_req(REQ_ROTATE, 32'hffff_ffff, 8'd0);  // empty wins over bad amount
    add_req(REQ_INS_AT, 32'd1, 8'd1);
    add_req(REQ_INS_AT, 32'h7fff_ffff, 8'd0);
    add_req(REQ_INS_FRONT, 32'h8000_0000, 8'd0);
    add_req(REQ_INS_BACK, 32'd0, 8'd0);
    add_req(REQ_INS_AT, 32'hffff_ffff, 8'd3);  // position equal to count appends
    add_req(REQ_INS_AT, 32'd5, 8'd2);
    add_req(REQ_INS_BACK, 32'd6, 8'd0);
    add_req(REQ_INS_BACK, 32'd7, 8'd0);
    add_req(REQ_INS_FRONT, 32'h8000_0000, 8'd0);
    add_req(REQ_INS_FRONT, 32'd9, 8'd0);
    add_req(REQ_INS_AT, 32'd9, 8'd255);        // full wins over bad position
    add_req(REQ_SEARCH, 32'h8000_0000, 8'd0);
    add_req(REQ_SEARCH, 32'h1234_5678, 8'd0);
    add_req(REQ_ROTATE, 32'h8000_0000, 8'd0);
    add_req(REQ_ROTATE, 32'd8, 8'd0);
    add_req(REQ_ROTATE, 32'h7fff_ffff, 8'd0);
    add_req(REQ_ROTATE, 32'd3, 8'd0);
    add_req(REQ_DEL_AT, 32'd0, 8'd255);
    add_req(REQ_DEL_AT, 32'd0, 8'd8);
    add_req(REQ_DEL_AT, 32'd0, 8'd3);
    add_req(REQ_DEL_BACK, 32'd0, 8'd0);

    foreach (word_pool[i]) word_pool[i] = $urandom;
    word_pool[0] = 32'h8000_0000;
    word_pool[1] = 32'h7fff_ffff;

    // random: phases lean toward filling, draining or reordering the list
    for (int n = 0; n < 1325; n++) begin
      if (n % 24 == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: begin ins_pct = 65; del_pct = 15; srch_pct = 10; end
        1: begin ins_pct = 15; del_pct = 65; srch_pct = 10; end
        default: begin ins_pct = 25; del_pct = 25; srch_pct = 25; end
      endcase
      roll = $urandom_range(0, 99);
      r.drain_first = (n % 330 == 200);
      r.position    = ($urandom_range(0, 4) == 0) ? pos_t'($urandom) :
                                                    pos_t'($urandom_range(0, 9));
      if ($urandom_range(0, 19) == 0) begin
        // noise: anything at all
        r.kind  = req_e'($urandom);
        r.value = $urandom;
      end else if (roll < ins_pct) begin
        r.kind  = ins_kinds[$urandom_range(0, 2)];
        r.value = pick_word();
      end else if (roll < ins_pct + del_pct) begin
        r.kind  = del_kinds[$urandom_range(0, 2)];
        r.value = $urandom;
      end else if (roll < ins_pct + del_pct + srch_pct) begin
        r.kind  = REQ_SEARCH;
        r.value = pick_word();
      end else begin
        r.kind = REQ_ROTATE;
        roll   = $urandom_range(0, 99);
        if (roll < 50) r.value = $urandom_range(0, 17);
        else if (roll < 70) r.value = {1'b0, 31'($urandom)};
        else if (roll < 85) r.value = {1'b1, 31'($urandom)};
        else r.value = $urandom;
      end
      req_q.push_back(r);
    end
    total_reqs = req_q.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (DrainLen) @(posedge clk_i);

    if (fail_cnt == 0 && want_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== array_list_engine.f =====
rtl/alist_pkg.sv
rtl/alist_cell.sv
rtl/alist_mod.sv
rtl/array_list_engine.sv
tb/sv/array_list_engine_test.sv
